>>> design/rpr_pkg.sv
package rpr_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int SCALE_W = 24;
  localparam int FREQ_W  = 32;
  localparam int P_W     = FREQ_W + SCALE_W + 1;  // frequency x scale, Q19.38
  localparam int A_W     = FREQ_W + SCALE_W - 8;  // angle Q18.30 before reduction
  localparam int QH_W    = 16;                    // quotient estimate
  localparam int QT_W    = A_W + 2;
  localparam int ANG_W   = 36;                    // remainder, signed
  localparam int ANGU_W  = 33;                    // reduced angle, unsigned
  localparam int XY_W    = 32;
  localparam int Z_W     = 34;
  localparam int CS_W    = XY_W + 1;
  localparam int PROD_W  = DATA_WIDTH + CS_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int RND_W   = SUM_W - 30;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd1048576;

  localparam logic signed [ANG_W-1:0] TWO_PI_Q30   = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_HALF3_Q30 = 36'sd5059889139;

  // floor(2^48 / (2*pi*2^30)), i.e. 2/pi in Q16
  localparam logic signed [16:0] RECIP_Q16 = 17'sd41721;

  localparam logic signed [XY_W-1:0] KINV_Q30 = 32'sd652032874;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(536870912);

  // pipeline stage indexes
  localparam int ST_CORR    = 3;
  localparam int ST_FOLD    = 4;
  localparam int NUM_STAGES = CORDIC_STAGES + 9;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] first;
    logic signed [DATA_WIDTH-1:0] second;
    logic                         rot;
    logic                         partner;
    logic                         neg;
  } rpr_side_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] first_out;
    logic signed [DATA_WIDTH-1:0] second_out;
    logic                         saturated;
    logic                         rot;
    logic                         partner;
  } rpr_res_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 34'sd843314857;
      1:       v = 34'sd497837829;
      2:       v = 34'sd263043837;
      3:       v = 34'sd133525159;
      4:       v = 34'sd67021687;
      5:       v = 34'sd33543516;
      6:       v = 34'sd16775851;
      7:       v = 34'sd8388437;
      8:       v = 34'sd4194283;
      9:       v = 34'sd2097149;
      10:      v = 34'sd1048576;
      11:      v = 34'sd524288;
      12:      v = 34'sd262144;
      13:      v = 34'sd131072;
      14:      v = 34'sd65536;
      15:      v = 34'sd32768;
      16:      v = 34'sd16384;
      17:      v = 34'sd8192;
      18:      v = 34'sd4096;
      19:      v = 34'sd2048;
      20:      v = 34'sd1024;
      21:      v = 34'sd512;
      22:      v = 34'sd256;
      23:      v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/rpr_in_if.sv
interface rpr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rpr_pkg::DATA_WIDTH-1:0] first_value;
  logic signed [rpr_pkg::DATA_WIDTH-1:0] second_value;
  logic signed [rpr_pkg::FREQ_W-1:0]     frequency;
  logic                                 rotate_enable;
  logic                                 has_partner;

  modport source (output valid, first_value, second_value, frequency, rotate_enable,
                  has_partner, input ready);
  modport sink (input valid, first_value, second_value, frequency, rotate_enable,
                has_partner, output ready);
endinterface

>>> design/rpr_out_if.sv
interface rpr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rpr_pkg::DATA_WIDTH-1:0] first_out;
  logic signed [rpr_pkg::DATA_WIDTH-1:0] second_out;
  logic                                 saturated;

  modport source (output valid, first_out, second_out, saturated, input ready);
  modport sink (input valid, first_out, second_out, saturated, output ready);
endinterface

>>> design/rpr_cfg_if.sv
interface rpr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rpr_pkg::SCALE_W-1:0]   angle_scale;

  modport source (output valid, angle_scale, input ready);
  modport sink (input valid, angle_scale, output ready);
endinterface

>>> design/rpr_cordic.sv
module rpr_cordic (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic signed [rpr_pkg::Z_W-1:0]      z_i,
  input  rpr_pkg::rpr_side_t                  side_i,
  output logic signed [rpr_pkg::XY_W-1:0]     x_o,
  output logic signed [rpr_pkg::XY_W-1:0]     y_o,
  output rpr_pkg::rpr_side_t                  side_o
);

  logic signed [rpr_pkg::XY_W-1:0] x_q    [rpr_pkg::CORDIC_STAGES];
  logic signed [rpr_pkg::XY_W-1:0] y_q    [rpr_pkg::CORDIC_STAGES];
  logic signed [rpr_pkg::Z_W-1:0]  z_q    [rpr_pkg::CORDIC_STAGES];
  rpr_pkg::rpr_side_t              side_q [rpr_pkg::CORDIC_STAGES];

  // one rotation step per register stage, shift amount fixed by position
  for (genvar g = 0; g < rpr_pkg::CORDIC_STAGES; g++) begin : g_stage
    logic signed [rpr_pkg::XY_W-1:0] x_in;
    logic signed [rpr_pkg::XY_W-1:0] y_in;
    logic signed [rpr_pkg::Z_W-1:0]  z_in;
    rpr_pkg::rpr_side_t              side_in;

    if (g == 0) begin : g_head
      assign x_in    = rpr_pkg::KINV_Q30;
      assign y_in    = '0;
      assign z_in    = z_i;
      assign side_in = side_i;
    end else begin : g_body
      assign x_in    = x_q[g-1];
      assign y_in    = y_q[g-1];
      assign z_in    = z_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[g] <= side_in;
        if (!z_in[rpr_pkg::Z_W-1]) begin
          x_q[g] <= x_in - (y_in >>> g);
          y_q[g] <= y_in + (x_in >>> g);
          z_q[g] <= z_in - rpr_pkg::atan_q30(g);
        end else begin
          x_q[g] <= x_in + (y_in >>> g);
          y_q[g] <= y_in - (x_in >>> g);
          z_q[g] <= z_in + rpr_pkg::atan_q30(g);
        end
      end
    end
  end

  assign x_o    = x_q[rpr_pkg::CORDIC_STAGES-1];
  assign y_o    = y_q[rpr_pkg::CORDIC_STAGES-1];
  assign side_o = side_q[rpr_pkg::CORDIC_STAGES-1];

endmodule

>>> design/rotary_position_rotation.sv
// Channel     Dir  Handshake     Payload
// pair_in     in   valid/ready   first_value, second_value, frequency, rotate_enable,
//                                has_partner
// result_out  out  valid/ready   first_out, second_out, saturated
// cfg_wr      in   valid/ready   angle_scale (ready is always high)
//
// One item per cycle while the skid register is empty. Items pass through the
// multiply/reduce front end, one CORDIC step per stage and the rotate tail.
// Reset clears the valid bits and the skid stage and loads angle_scale with 1.0 (Q4.20).
// The whole pipe advances together; a result that is not taken moves into a one-entry
// skid register, and pair_in.ready drops (registered) only while that register is full.
module rotary_position_rotation (
  input  logic             clk_i,
  input  logic             rst_ni,
  rpr_in_if.sink           pair_in,
  rpr_out_if.source        result_out,
  rpr_cfg_if.sink          cfg_wr
);

  localparam int Last = rpr_pkg::NUM_STAGES - 1;

  // control
  logic [rpr_pkg::NUM_STAGES-1:0] v_q;
  logic                           skid_full_q;
  logic [rpr_pkg::SCALE_W-1:0]    scale_q;
  logic                           adv;

  // stage 0: frequency x scale
  logic signed [rpr_pkg::P_W-1:0]    p0_q;
  rpr_pkg::rpr_side_t                sb0_q;
  // stage 1: floor to Q18.30, quotient estimate by 2pi
  logic signed [rpr_pkg::A_W-1:0]    a_w;
  logic signed [32:0]                qest;
  logic signed [rpr_pkg::A_W-1:0]    a1_q;
  logic signed [rpr_pkg::QH_W-1:0]   qh1_q;
  rpr_pkg::rpr_side_t                sb1_q;
  // stage 2: raw remainder
  logic signed [rpr_pkg::QT_W-1:0]   qt;
  logic signed [rpr_pkg::QT_W-1:0]   rem;
  logic signed [rpr_pkg::ANG_W-1:0]  r2_q;
  rpr_pkg::rpr_side_t                sb2_q;
  // stage 3: remainder correction into [0, 2pi)
  logic signed [rpr_pkg::ANG_W-1:0]  corr;
  logic [rpr_pkg::ANGU_W-1:0]        ang3_q;
  rpr_pkg::rpr_side_t                sb3_q;
  // stage 4: fold into [-pi/2, pi/2]
  logic signed [rpr_pkg::ANG_W-1:0]  ae;
  logic signed [rpr_pkg::ANG_W-1:0]  zf;
  logic                              negf;
  logic signed [rpr_pkg::Z_W-1:0]    z4_q;
  rpr_pkg::rpr_side_t                sb4_q;
  // CORDIC
  logic signed [rpr_pkg::XY_W-1:0]   xc;
  logic signed [rpr_pkg::XY_W-1:0]   yc;
  rpr_pkg::rpr_side_t                sbc;
  // sign fix, products, sums, saturate
  logic signed [rpr_pkg::CS_W-1:0]   cx;
  logic signed [rpr_pkg::CS_W-1:0]   sx;
  logic signed [rpr_pkg::CS_W-1:0]   c5_q;
  logic signed [rpr_pkg::CS_W-1:0]   s5_q;
  rpr_pkg::rpr_side_t                sb5_q;
  logic signed [rpr_pkg::PROD_W-1:0] pqc_q;
  logic signed [rpr_pkg::PROD_W-1:0] prs_q;
  logic signed [rpr_pkg::PROD_W-1:0] pqs_q;
  logic signed [rpr_pkg::PROD_W-1:0] prc_q;
  rpr_pkg::rpr_side_t                sb6_q;
  logic signed [rpr_pkg::SUM_W-1:0]  u0_q;
  logic signed [rpr_pkg::SUM_W-1:0]  u1_q;
  rpr_pkg::rpr_side_t                sb7_q;
  logic [rpr_pkg::DATA_WIDTH:0]      sat0;
  logic [rpr_pkg::DATA_WIDTH:0]      sat1;
  rpr_pkg::rpr_res_t                 res_d;
  rpr_pkg::rpr_res_t                 res8_q;
  rpr_pkg::rpr_res_t                 skid_q;
  rpr_pkg::rpr_res_t                 out_res;

  // round already applied; take the integer part and clip to DATA_WIDTH
  // returns {clip, value}
  function automatic logic [rpr_pkg::DATA_WIDTH:0] clip_fn(
    input logic signed [rpr_pkg::SUM_W-1:0] u);
    logic signed [rpr_pkg::RND_W-1:0] v;
    logic                             ovf;
    v   = u[rpr_pkg::SUM_W-1:30];
    ovf = v[rpr_pkg::RND_W-1:rpr_pkg::DATA_WIDTH-1] !=
          {(rpr_pkg::RND_W - rpr_pkg::DATA_WIDTH + 1){v[rpr_pkg::RND_W-1]}};
    if (!ovf) begin
      return {1'b0, v[rpr_pkg::DATA_WIDTH-1:0]};
    end else if (v[rpr_pkg::RND_W-1]) begin
      return {1'b1, 1'b1, {(rpr_pkg::DATA_WIDTH-1){1'b0}}};
    end
    return {1'b1, 1'b0, {(rpr_pkg::DATA_WIDTH-1){1'b1}}};
  endfunction

  assign adv           = !skid_full_q;
  assign pair_in.ready = !skid_full_q;
  assign cfg_wr.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      skid_full_q <= 1'b0;
      scale_q     <= rpr_pkg::SCALE_RESET;
    end else begin
      if (adv) begin
        v_q <= {v_q[rpr_pkg::NUM_STAGES-2:0], pair_in.valid};
      end
      if (skid_full_q) begin
        skid_full_q <= !result_out.ready;
      end else begin
        skid_full_q <= v_q[Last] && !result_out.ready;
      end
      if (cfg_wr.valid) begin
        scale_q <= cfg_wr.angle_scale;
      end
    end
  end

  // ---- angle reduction front end ----
  assign a_w  = p0_q[rpr_pkg::A_W+7:8];
  assign qest = $signed(a_w[rpr_pkg::A_W-1:32]) * rpr_pkg::RECIP_Q16;
  assign qt   = qh1_q * rpr_pkg::TWO_PI_Q30;
  assign rem  = a1_q - qt;

  // estimate leaves the remainder within (-2pi, 4pi); one step of correction
  always_comb begin
    if (r2_q[rpr_pkg::ANG_W-1]) begin
      corr = r2_q + rpr_pkg::TWO_PI_Q30;
    end else if (r2_q >= rpr_pkg::TWO_PI_Q30) begin
      corr = r2_q - rpr_pkg::TWO_PI_Q30;
    end else begin
      corr = r2_q;
    end
  end

  // middle half-turn is shifted by pi and flips the sign of cos/sin
  always_comb begin
    ae   = $signed({3'b000, ang3_q});
    negf = 1'b0;
    if (ae <= rpr_pkg::HALF_PI_Q30) begin
      zf = ae;
    end else if (ae < rpr_pkg::PI_HALF3_Q30) begin
      zf   = ae - rpr_pkg::PI_Q30;
      negf = 1'b1;
    end else begin
      zf = ae - rpr_pkg::TWO_PI_Q30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q          <= pair_in.frequency * $signed({1'b0, scale_q});
      sb0_q.first   <= pair_in.first_value;
      sb0_q.second  <= pair_in.has_partner ? pair_in.second_value : '0;
      sb0_q.rot     <= pair_in.rotate_enable;
      sb0_q.partner <= pair_in.has_partner;
      sb0_q.neg     <= 1'b0;

      a1_q  <= a_w;
      qh1_q <= qest[31:16];
      sb1_q <= sb0_q;

      r2_q  <= rem[rpr_pkg::ANG_W-1:0];
      sb2_q <= sb1_q;

      ang3_q <= corr[rpr_pkg::ANGU_W-1:0];
      sb3_q  <= sb2_q;

      z4_q          <= zf[rpr_pkg::Z_W-1:0];
      sb4_q.first   <= sb3_q.first;
      sb4_q.second  <= sb3_q.second;
      sb4_q.rot     <= sb3_q.rot;
      sb4_q.partner <= sb3_q.partner;
      sb4_q.neg     <= negf;
    end
  end

  rpr_cordic u_cordic (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .z_i    (z4_q),
    .side_i (sb4_q),
    .x_o    (xc),
    .y_o    (yc),
    .side_o (sbc)
  );

  // ---- rotation tail ----
  assign cx = {xc[rpr_pkg::XY_W-1], xc};
  assign sx = {yc[rpr_pkg::XY_W-1], yc};

  always_comb begin
    sat0              = clip_fn(u0_q);
    sat1              = clip_fn(u1_q);
    res_d.rot         = sb7_q.rot;
    res_d.partner     = sb7_q.partner;
    if (!sb7_q.rot) begin
      res_d.first_out  = sb7_q.first;
      res_d.second_out = sb7_q.second;
      res_d.saturated  = 1'b0;
    end else begin
      res_d.first_out  = sat0[rpr_pkg::DATA_WIDTH-1:0];
      res_d.second_out = sb7_q.partner ? sat1[rpr_pkg::DATA_WIDTH-1:0] : '0;
      res_d.saturated  = sat0[rpr_pkg::DATA_WIDTH] |
                         (sb7_q.partner & sat1[rpr_pkg::DATA_WIDTH]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c5_q  <= sbc.neg ? -cx : cx;
      s5_q  <= sbc.neg ? -sx : sx;
      sb5_q <= sbc;

      pqc_q <= $signed(sb5_q.first) * c5_q;
      prs_q <= $signed(sb5_q.second) * s5_q;
      pqs_q <= $signed(sb5_q.first) * s5_q;
      prc_q <= $signed(sb5_q.second) * c5_q;
      sb6_q <= sb5_q;

      u0_q  <= pqc_q - prs_q + rpr_pkg::RND_HALF;
      u1_q  <= pqs_q + prc_q + rpr_pkg::RND_HALF;
      sb7_q <= sb6_q;

      res8_q <= res_d;
    end
    // park the last stage's result when the sink holds off
    if (adv && v_q[Last] && !result_out.ready) begin
      skid_q <= res8_q;
    end
  end

  assign out_res               = skid_full_q ? skid_q : res8_q;
  assign result_out.valid      = skid_full_q | v_q[Last];
  assign result_out.first_out  = out_res.first_out;
  assign result_out.second_out = out_res.second_out;
  assign result_out.saturated  = out_res.saturated;

`ifndef SYNTH
  a_ang_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[rpr_pkg::ST_CORR] |-> $signed({3'b000, ang3_q}) < rpr_pkg::TWO_PI_Q30)
    else $error("reduced angle not below 2pi");

  a_fold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[rpr_pkg::ST_FOLD] |->
      (z4_q >= -rpr_pkg::HALF_PI_Q30) && (z4_q <= rpr_pkg::HALF_PI_Q30))
    else $error("folded angle outside half-turn");

  a_lone_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_out.valid && !out_res.partner |-> result_out.second_out == '0)
    else $error("lone element gave nonzero second output");

  a_sat_rot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_out.valid && result_out.saturated |-> out_res.rot)
    else $error("saturation flagged on pass-through item");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(result_out.valid && !result_out.ready))
    else $error("skid filled without a stalled result");
`endif

endmodule
